// ----- src/sle_pkg.sv -----
// sle_pkg: shared constants and types for the sequential list engine
// holds list capacity, field widths, operation codes and sequencer states
// no dependencies
package sle_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int LEN_W    = $clog2(CAPACITY + 1);

    // fixed request and result field widths
    localparam int OP_W     = 3;
    localparam int POS_W    = 7;
    localparam int VAL_W    = 8;
    localparam int POUT_W   = 6;
    localparam int CNT_W    = 7;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 32;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_READ   = 3'd2,
        OP_LOCATE = 3'd3,
        OP_PURGE  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

endpackage

// ----- src/sequential_list_engine.sv -----
// sequential_list_engine: ordered byte list kept in one synchronous ram with a length count
// insert, delete, read, locate and delete-all-equal by sequential memory sweeps
// depends on sle_pkg
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser: operation; tdata: position, value
// m_axis    out  m_axis_tvalid / m_axis_tready  tuser: ok; tdata: value_out .. length_out
//
// one request is worked at a time; the element ram has one read and one write port
// and a registered read, so a sweep shifts or scans the elements one after another
// an item goes from its transfer through a sweep of up to CAPACITY elements, possibly none,
// to its result; a locate match cuts the sweep short
// reset clears the length and the control state only; the ram needs no clearing
// the result sits in an output register, so a new request is taken while it waits;
// that request then holds in its final state until the register drains
module sequential_list_engine
    import sle_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // request channel
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [OP_W-1:0]  s_axis_tuser,   // operation [2:0]
    input  logic [IN_W-1:0]  s_axis_tdata,   // position [6:0], value [14:7], zero [15]
    // result channel
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic             m_axis_tuser,   // ok [0]
    output logic [OUT_W-1:0] m_axis_tdata    // value_out [7:0], position_out [13:8],
                                             // removed_count [20:14], length_out [27:21],
                                             // zero [31:28]
);

    // element ram
    logic [VAL_W-1:0]  r_mem [CAPACITY];
    logic [VAL_W-1:0]  r_rd_data;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [VAL_W-1:0]  mem_wd;

    // control state
    t_state            r_state, n_state;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_pend, n_pend;     // read data arrives this cycle
    logic              r_m_valid, n_m_valid;

    // request context and sweep counters
    logic [OP_W-1:0]   r_op, n_op;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [VAL_W-1:0]  r_val, n_val;
    logic [ADDR_W-1:0] r_addr, n_addr;     // next read address
    logic [LEN_W-1:0]  r_rem, n_rem;       // reads still to issue
    logic [ADDR_W-1:0] r_pidx, n_pidx;     // index of the data now arriving
    logic [LEN_W-1:0]  r_kept, n_kept;     // write pointer for compaction

    // result being built
    logic              r_ok, n_ok;
    logic [VAL_W-1:0]  r_vout, n_vout;
    logic [POUT_W-1:0] r_pout, n_pout;

    // output register
    logic              r_m_ok, n_m_ok;
    logic [VAL_W-1:0]  r_m_vout, n_m_vout;
    logic [POUT_W-1:0] r_m_pout, n_m_pout;
    logic [CNT_W-1:0]  r_m_rmcnt, n_m_rmcnt;
    logic [LEN_W-1:0]  r_m_len, n_m_len;

    logic [POS_W-1:0]  in_pos;
    logic [VAL_W-1:0]  in_val;
    logic              out_free;

    assign in_pos   = s_axis_tdata[POS_W-1:0];
    assign in_val   = s_axis_tdata[POS_W+VAL_W-1:POS_W];
    assign out_free = !r_m_valid || m_axis_tready;

    // no transfer is taken while reset is held
    assign s_axis_tready = i_rst_n && (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_ok;
    assign m_axis_tdata  = {(OUT_W - VAL_W - POUT_W - CNT_W - LEN_W)'(0),
                            r_m_len, r_m_rmcnt, r_m_pout, r_m_vout};

    // ram: one write port, registered read at the sweep address
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[r_addr];
    end

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_pend    = r_pend;
        n_m_valid = r_m_valid;
        n_op      = r_op;
        n_pos     = r_pos;
        n_val     = r_val;
        n_addr    = r_addr;
        n_rem     = r_rem;
        n_pidx    = r_pidx;
        n_kept    = r_kept;
        n_ok      = r_ok;
        n_vout    = r_vout;
        n_pout    = r_pout;
        n_m_ok    = r_m_ok;
        n_m_vout  = r_m_vout;
        n_m_pout  = r_m_pout;
        n_m_rmcnt = r_m_rmcnt;
        n_m_len   = r_m_len;
        mem_we    = 1'b0;
        mem_wa    = '0;
        mem_wd    = '0;

        // result register drains on transfer
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op   = s_axis_tuser;
                    n_pos  = in_pos;
                    n_val  = in_val;
                    n_ok   = 1'b0;
                    n_vout = '0;
                    n_pout = '0;
                    n_kept = r_len;
                    n_pend = 1'b0;
                    n_rem  = '0;
                    n_addr = '0;
                    n_state = ST_FIN;
                    case (s_axis_tuser)
                        OP_INSERT: begin
                            // sweep downward from the last element, each moves up one
                            if (r_len < LEN_W'(CAPACITY) && in_pos <= POS_W'(r_len)) begin
                                n_ok    = 1'b1;
                                n_rem   = r_len - LEN_W'(in_pos);
                                n_addr  = ADDR_W'(r_len - LEN_W'(1));
                                n_state = ST_SCAN;
                            end
                        end
                        OP_DELETE: begin
                            // first read gives the removed element, the rest move down
                            if (in_pos < POS_W'(r_len)) begin
                                n_ok    = 1'b1;
                                n_rem   = r_len - LEN_W'(in_pos);
                                n_addr  = ADDR_W'(in_pos);
                                n_state = ST_SCAN;
                            end
                        end
                        OP_READ: begin
                            if (in_pos < POS_W'(r_len)) begin
                                n_ok    = 1'b1;
                                n_rem   = LEN_W'(1);
                                n_addr  = ADDR_W'(in_pos);
                                n_state = ST_SCAN;
                            end
                        end
                        OP_LOCATE: begin
                            n_rem   = r_len;
                            n_state = ST_SCAN;
                        end
                        OP_PURGE: begin
                            if (r_len != '0) begin
                                n_ok    = 1'b1;
                                n_rem   = r_len;
                                n_kept  = '0;
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                            n_state = ST_FIN;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // issue the next read
                if (r_rem != '0) begin
                    n_rem  = r_rem - LEN_W'(1);
                    n_pend = 1'b1;
                    n_pidx = r_addr;
                    if (r_op == OP_INSERT) begin
                        n_addr = r_addr - ADDR_W'(1);
                    end else begin
                        n_addr = r_addr + ADDR_W'(1);
                    end
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = ST_FIN;
                    end
                end

                // consume the data read last cycle
                if (r_pend) begin
                    case (r_op)
                        OP_INSERT: begin
                            mem_we = 1'b1;
                            mem_wa = r_pidx + ADDR_W'(1);
                            mem_wd = r_rd_data;
                        end
                        OP_DELETE: begin
                            if (POS_W'(r_pidx) == r_pos) begin
                                n_vout = r_rd_data;
                            end else begin
                                mem_we = 1'b1;
                                mem_wa = r_pidx - ADDR_W'(1);
                                mem_wd = r_rd_data;
                            end
                        end
                        OP_READ: begin
                            n_vout = r_rd_data;
                        end
                        OP_LOCATE: begin
                            // first match ends the sweep
                            if (r_rd_data == r_val) begin
                                n_ok    = 1'b1;
                                n_pout  = POUT_W'(r_pidx);
                                n_rem   = '0;
                                n_pend  = 1'b0;
                                n_state = ST_FIN;
                            end
                        end
                        OP_PURGE: begin
                            // keep-pointer never passes the read pointer
                            if (r_rd_data != r_val) begin
                                mem_we = 1'b1;
                                mem_wa = ADDR_W'(r_kept);
                                mem_wd = r_rd_data;
                                n_kept = r_kept + LEN_W'(1);
                            end
                        end
                        default: begin
                            mem_we = 1'b0;
                        end
                    endcase
                end
            end

            ST_FIN: begin
                // insert drops its value into the gap; repeating it while stalled is harmless
                if (r_op == OP_INSERT && r_ok) begin
                    mem_we = 1'b1;
                    mem_wa = ADDR_W'(r_pos);
                    mem_wd = r_val;
                end
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_ok    = r_ok;
                    n_m_vout  = r_vout;
                    n_m_pout  = r_pout;
                    n_m_rmcnt = '0;
                    if (r_ok) begin
                        case (r_op)
                            OP_INSERT: n_len = r_len + LEN_W'(1);
                            OP_DELETE: n_len = r_len - LEN_W'(1);
                            OP_PURGE: begin
                                n_len     = r_kept;
                                n_m_rmcnt = CNT_W'(r_len - r_kept);
                            end
                            default:   n_len = r_len;
                        endcase
                    end
                    n_m_len = (r_ok && (r_op inside {OP_INSERT, OP_DELETE, OP_PURGE}))
                              ? n_len : r_len;
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_len     <= '0;
            r_pend    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_pend    <= n_pend;
            r_m_valid <= n_m_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_pos     <= n_pos;
        r_val     <= n_val;
        r_addr    <= n_addr;
        r_rem     <= n_rem;
        r_pidx    <= n_pidx;
        r_kept    <= n_kept;
        r_ok      <= n_ok;
        r_vout    <= n_vout;
        r_pout    <= n_pout;
        r_m_ok    <= n_m_ok;
        r_m_vout  <= n_m_vout;
        r_m_pout  <= n_m_pout;
        r_m_rmcnt <= n_m_rmcnt;
        r_m_len   <= n_m_len;
    end

endmodule

// ----- dv/sle_checker.sv -----
// sle_checker: watches the request and result streams of the sequential list engine,
// keeps its own copy of the list, predicts every result and compares it field by field
// depends on sle_pkg
module sle_checker
    import sle_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_tready,
    input  logic [OP_W-1:0]  i_s_tuser,   // operation [2:0]
    input  logic [IN_W-1:0]  i_s_tdata,   // position [6:0], value [14:7], zero [15]
    input  logic             i_m_tvalid,
    input  logic             i_m_tready,
    input  logic             i_m_tuser,   // ok [0]
    input  logic [OUT_W-1:0] i_m_tdata,   // value_out [7:0], position_out [13:8],
                                          // removed_count [20:14], length_out [27:21],
                                          // zero [31:28]
    output int               o_fail_count,
    output int               o_pending,
    output logic [LEN_W-1:0] o_list_len
);

    typedef struct packed {
        logic              ok;
        logic [VAL_W-1:0]  value_out;
        logic [POUT_W-1:0] position_out;
        logic [CNT_W-1:0]  removed_count;
        logic [LEN_W-1:0]  length_out;
    } t_list_result;

    // private copy of the list
    logic [VAL_W-1:0] elem_mem [CAPACITY];
    int               elem_count;

    t_list_result     predicted_results [$];
    t_list_result     want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_list_len   = '0;
        elem_count   = 0;
    end

    // applies one request to the private list and returns what the engine should answer
    function automatic t_list_result run_list_op(input logic [OP_W-1:0]  op,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic [VAL_W-1:0] val);
        t_list_result res;
        int           i;
        int           kept;
        res = '0;
        case (op)
            OP_INSERT: begin
                if (elem_count < CAPACITY && int'(pos) <= elem_count) begin
                    for (i = elem_count; i > int'(pos); i--)
                        elem_mem[ADDR_W'(i)] = elem_mem[ADDR_W'(i - 1)];
                    elem_mem[ADDR_W'(pos)] = val;
                    elem_count++;
                    res.ok = 1'b1;
                end
            end
            OP_DELETE: begin
                if (int'(pos) < elem_count) begin
                    res.ok        = 1'b1;
                    res.value_out = elem_mem[ADDR_W'(pos)];
                    for (i = int'(pos); i + 1 < elem_count; i++)
                        elem_mem[ADDR_W'(i)] = elem_mem[ADDR_W'(i + 1)];
                    elem_count--;
                end
            end
            OP_READ: begin
                if (int'(pos) < elem_count) begin
                    res.ok        = 1'b1;
                    res.value_out = elem_mem[ADDR_W'(pos)];
                end
            end
            OP_LOCATE: begin
                for (i = 0; i < elem_count; i++) begin
                    if (!res.ok && elem_mem[ADDR_W'(i)] == val) begin
                        res.ok           = 1'b1;
                        res.position_out = POUT_W'(i);
                    end
                end
            end
            OP_PURGE: begin
                // compaction keeps the order of the survivors
                if (elem_count != 0) begin
                    kept = 0;
                    for (i = 0; i < elem_count; i++) begin
                        if (elem_mem[ADDR_W'(i)] != val) begin
                            elem_mem[ADDR_W'(kept)] = elem_mem[ADDR_W'(i)];
                            kept++;
                        end
                    end
                    res.ok            = 1'b1;
                    res.removed_count = CNT_W'(elem_count - kept);
                    elem_count        = kept;
                end
            end
            default: ;  // unused codes change nothing
        endcase
        res.length_out = LEN_W'(elem_count);
        return res;
    endfunction

    task automatic compare_field(input string field, input int unsigned expv,
                                 input int unsigned actv);
        if (expv != actv) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, expv, actv);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            elem_count = 0;
            predicted_results.delete();
        end else begin
            // result side first so that a stray result is never matched to a new request
            if (i_m_tvalid && i_m_tready) begin
                if (predicted_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: result transfer with nothing outstanding, tdata %h",
                                 $time, i_m_tdata);
                end else begin
                    want = predicted_results.pop_front();
                    compare_field("ok", 32'(want.ok), 32'(i_m_tuser));
                    compare_field("value_out", 32'(want.value_out), 32'(i_m_tdata[7:0]));
                    compare_field("position_out", 32'(want.position_out),
                                  32'(i_m_tdata[13:8]));
                    compare_field("removed_count", 32'(want.removed_count),
                                  32'(i_m_tdata[20:14]));
                    compare_field("length_out", 32'(want.length_out), 32'(i_m_tdata[27:21]));
                    compare_field("tdata padding", 0, 32'(i_m_tdata[31:28]));
                end
            end
            if (i_s_tvalid && i_s_tready)
                predicted_results.push_back(run_list_op(i_s_tuser, i_s_tdata[POS_W-1:0],
                                                        i_s_tdata[POS_W+VAL_W-1:POS_W]));
        end
        o_pending  = predicted_results.size();
        o_list_len = LEN_W'(elem_count);
    end

endmodule

// ----- dv/tb_sequential_list_engine.sv -----
// tb_sequential_list_engine: stimulus and verdict for the sequential list engine
// drives directed and episode-shaped random requests with bursty idling on both streams
// depends on sle_pkg, sequential_list_engine and sle_checker
module tb_sequential_list_engine
    import sle_pkg::*;
();

    typedef enum {EP_GROW, EP_SHRINK, EP_MIXED, EP_FILL} t_episode;

    localparam int RANDOM_ITEMS = 850;
    localparam int QUIET_TAIL   = 760;   // no idling from here on
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 80;    // longer than one full sweep of the list
    localparam logic [OP_W-1:0] UNUSED_SPAN = OP_W'((1 << OP_W) - 1 - OP_PURGE);

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [OP_W-1:0]  s_axis_tuser = '0;   // operation [2:0]
    logic [IN_W-1:0]  s_axis_tdata = '0;   // position [6:0], value [14:7], zero [15]
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic             m_axis_tuser;        // ok [0]
    logic [OUT_W-1:0] m_axis_tdata;        // value_out [7:0], position_out [13:8],
                                           // removed_count [20:14], length_out [27:21]

    int               chk_fail_count;
    int               chk_pending;
    logic [LEN_W-1:0] chk_list_len;

    bit               tx_idle_on = 1'b1;
    bit               rx_idle_on = 1'b1;
    bit               rx_hold_req = 1'b0;
    int               items_sent = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    sequential_list_engine u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata)
    );

    sle_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tuser    (s_axis_tuser),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tdata    (m_axis_tdata),
        .o_fail_count (chk_fail_count),
        .o_pending    (chk_pending),
        .o_list_len   (chk_list_len)
    );

    // one request transfer, then maybe a burst of idle cycles
    task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                             input logic [VAL_W-1:0] val);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_W-POS_W-VAL_W){1'b0}}, val, pos};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        if (op <= OP_PURGE)
            items_sent++;
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    // stop offering and wait until every outstanding result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [OP_W-1:0] pick_op(input t_episode kind);
        int r;
        int ins;
        int del;
        int rd;
        int loc;
        case (kind)
            EP_GROW:   begin ins = 60; del = 10; rd = 12; loc = 10; end
            EP_SHRINK: begin ins = 15; del = 45; rd = 12; loc = 10; end
            default:   begin ins = 35; del = 25; rd = 15; loc = 15; end
        endcase
        // a little noise with the unused codes
        if ($urandom_range(0, 39) == 0)
            return OP_W'(OP_PURGE + $urandom_range(1, UNUSED_SPAN));
        r = $urandom_range(0, 99);
        if (r < ins)
            return OP_INSERT;
        else if (r < ins + del)
            return OP_DELETE;
        else if (r < ins + del + rd)
            return OP_READ;
        else if (r < ins + del + rd + loc)
            return OP_LOCATE;
        else
            return OP_PURGE;
    endfunction

    // mostly in range, sometimes exactly the length, sometimes anywhere in the field
    function automatic logic [POS_W-1:0] pick_position(input logic [OP_W-1:0] op);
        int len;
        int r;
        len = int'(chk_list_len);
        r   = $urandom_range(0, 19);
        if (r == 0)
            return POS_W'($urandom_range(0, (1 << POS_W) - 1));
        else if (r == 1)
            return POS_W'(len);
        else if (op == OP_INSERT)
            return POS_W'($urandom_range(0, len));
        else
            return (len == 0) ? '0 : POS_W'($urandom_range(0, len - 1));
    endfunction

    // grow the list to capacity, hit the last slot with a unique value, then probe the edges
    task automatic fill_to_capacity();
        int base;
        int k;
        while (chk_list_len < CAPACITY - 2)
            send_item(OP_INSERT, POS_W'($urandom_range(0, chk_list_len)),
                      VAL_W'($urandom_range(0, 254)));
        drain_results();
        base = int'(chk_list_len);
        for (k = base; k < CAPACITY - 1; k++)
            send_item(OP_INSERT, POS_W'(k), VAL_W'($urandom_range(0, 254)));
        send_item(OP_INSERT, POS_W'(CAPACITY - 1), '1);
        send_item(OP_LOCATE, 0, '1);
        send_item(OP_INSERT, 0, VAL_W'($urandom_range(0, 255)));
        send_item(OP_INSERT, POS_W'(CAPACITY), VAL_W'($urandom_range(0, 255)));
        send_item(OP_READ, POS_W'(CAPACITY - 1), 0);
        send_item(OP_READ, POS_W'(CAPACITY), 0);
        send_item(OP_DELETE, POS_W'(CAPACITY - 1), 0);
    endtask

    // result side: bursty stalls, plus one long hold-off on request
    initial begin
        int hold_cnt;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
                    @(posedge i_clk);
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin
        t_episode kind;
        bit       narrow;
        bit       hold_done;
        int       ep_len;
        int       n;
        logic [OP_W-1:0] op;

        hold_done = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty list, edges of position and value, every operation
        send_item(OP_READ, 0, 0);
        send_item(OP_DELETE, 0, 0);
        send_item(OP_LOCATE, 0, 8'h00);
        send_item(OP_PURGE, 0, 8'h00);       // purge of an empty list
        send_item(OP_INSERT, 1, 8'h11);      // past the end
        send_item(OP_INSERT, 0, 8'hFF);
        send_item(OP_INSERT, 1, 8'h00);      // append
        send_item(OP_INSERT, 0, 8'hAA);      // front, shifts the rest
        send_item(OP_INSERT, 127, 8'h55);
        send_item(OP_INSERT, 1, 8'hAA);
        send_item(OP_READ, 0, 0);
        send_item(OP_READ, 3, 0);
        send_item(OP_READ, 4, 0);            // position equal to length
        send_item(OP_READ, 127, 0);
        send_item(OP_LOCATE, 0, 8'h00);
        send_item(OP_LOCATE, 0, 8'h55);      // no match
        send_item(OP_DELETE, 2, 0);
        send_item(OP_DELETE, 3, 0);
        send_item(OP_DELETE, 127, 0);
        send_item(OP_PURGE, 0, 8'h7F);       // nothing removed, still ok
        send_item(OP_PURGE, 0, 8'hAA);
        for (n = 1; n <= UNUSED_SPAN; n++)
            send_item(OP_W'(OP_PURGE + n), 127, 8'hFF);
        send_item(OP_DELETE, 0, 0);

        // random episodes, the first one fills the list
        items_sent = 0;
        kind = EP_FILL;
        while (items_sent < RANDOM_ITEMS) begin
            tx_idle_on = (items_sent < QUIET_TAIL) && ($urandom_range(0, 2) != 0);
            rx_idle_on = (items_sent < QUIET_TAIL) && ($urandom_range(0, 2) != 0);
            if (kind == EP_FILL) begin
                fill_to_capacity();
            end else begin
                narrow = ($urandom_range(0, 2) == 0);
                ep_len = $urandom_range(20, 60);
                for (n = 0; n < ep_len && items_sent < RANDOM_ITEMS; n++) begin
                    if (!hold_done && items_sent >= HOLD_AT) begin
                        // keep offering while the result side is held off
                        rx_hold_req = 1'b1;
                        hold_done   = 1'b1;
                        tx_idle_on  = 1'b0;
                    end
                    if (items_sent >= QUIET_TAIL) begin
                        tx_idle_on = 1'b0;
                        rx_idle_on = 1'b0;
                    end
                    op = pick_op(kind);
                    send_item(op, pick_position(op),
                              narrow ? VAL_W'($urandom_range(0, 3))
                                     : VAL_W'($urandom_range(0, 255)));
                end
            end
            case ($urandom_range(0, 7))
                0:       kind = EP_FILL;
                1, 2:    kind = EP_GROW;
                3, 4:    kind = EP_SHRINK;
                default: kind = EP_MIXED;
            endcase
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (chk_fail_count == 0 && chk_pending == 0)
            $display("sequential_list_engine test passed");
        else
            $display("sequential_list_engine test failed");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("sequential_list_engine test failed");
        $finish;
    end

endmodule
